/* rtl/rwa_pkg.sv */
package rwa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 5;
    localparam int TOTAL_W  = 21;
    localparam int MAG_W    = 20;
    localparam int STEP_W   = 5;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);
    localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(2);

    // Word index of the window length register.
    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
    } t_q_item;

    typedef struct packed {
        logic                      start;
        logic signed [TOTAL_W-1:0] dividend;
        logic [WIN_W-1:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/rwa_front.sv */
module rwa_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [rwa_pkg::SAMPLE_W-1:0] i_sample,
    output rwa_pkg::t_q_item                   o_item,
    input  logic                               i_pop
);
    import rwa_pkg::*;

    // Two-entry queue between the input port and the arithmetic.
    logic signed [SAMPLE_W-1:0] r_data [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != 2'd0);

    assign o_item.valid  = (r_cnt != 2'd0);
    assign o_item.sample = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wp] <= i_sample;
        end
    end

endmodule

/* rtl/rwa_div.sv */
module rwa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwa_pkg::t_div_req i_req,
    output rwa_pkg::t_div_rsp o_rsp
);
    import rwa_pkg::*;

    // Restoring divider on the magnitude, one quotient bit per cycle.
    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [WIN_W-1:0]    r_rem;
    logic [WIN_W-1:0]    r_den;
    logic                r_done;
    logic [SAMPLE_W-1:0] r_quot;

    logic [WIN_W:0]      rem_sh;
    logic                ge;
    logic [WIN_W:0]      rem_sub;
    logic [MAG_W-1:0]    mag_nx;
    logic [TOTAL_W-1:0]  abs_in;
    logic [SAMPLE_W-1:0] q_low;

    assign abs_in  = i_req.dividend[TOTAL_W-1] ? (-i_req.dividend) : i_req.dividend;
    assign rem_sh  = {r_rem, r_mag[MAG_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign mag_nx  = {r_mag[MAG_W-2:0], ge};
    assign q_low   = mag_nx[SAMPLE_W-1:0];

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_step == STEP_W'(MAG_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[TOTAL_W-1];
            r_mag <= abs_in[MAG_W-1:0];
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_mag <= mag_nx;
            r_rem <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
            if (r_step == STEP_W'(MAG_W - 1)) begin
                r_quot <= r_neg ? (-q_low) : q_low;
            end
        end
    end

endmodule

/* rtl/rwa_back.sv */
module rwa_back #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic [rwa_pkg::WIN_W-1:0]           i_window,
    input  rwa_pkg::t_q_item                    i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rwa_pkg::SAMPLE_W-1:0] o_average
);
    import rwa_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CMP_W  = (SLOT_W + 1 > WIN_W) ? SLOT_W + 1 : WIN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                      r_state;
    logic [SLOT_W-1:0]           r_slot;
    logic signed [TOTAL_W-1:0]   r_total;
    logic                        r_filled;
    logic [DEPTH-1:0]            r_vld;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic signed [SAMPLE_W-1:0]  r_rd_data;
    logic                        r_rd_vld;
    logic signed [SAMPLE_W-1:0]  r_res;
    logic                        r_o_valid;
    logic signed [SAMPLE_W-1:0]  r_o_avg;
    logic signed [SAMPLE_W-1:0]  r_mem [DEPTH];

    logic signed [SAMPLE_W-1:0]  old_val;
    logic signed [TOTAL_W-1:0]   n_total;
    logic [SLOT_W:0]             slot_inc;
    logic [CMP_W-1:0]            slot_cmp;
    logic                        wrap;
    logic [SLOT_W-1:0]           n_slot;
    logic                        n_filled;
    logic [WIN_W-1:0]            count;
    t_div_req                    div_req;
    t_div_rsp                    div_rsp;

    // An entry not written since the last clear reads as zero.
    assign old_val  = r_rd_vld ? r_rd_data : '0;
    assign n_total  = r_total - TOTAL_W'(old_val) + TOTAL_W'(r_sample);
    assign slot_inc = {1'b0, r_slot} + (SLOT_W + 1)'(1);
    assign slot_cmp = CMP_W'(slot_inc);
    assign wrap     = (slot_cmp >= CMP_W'(i_window));
    assign n_slot   = wrap ? '0 : slot_inc[SLOT_W-1:0];
    assign n_filled = r_filled || wrap;
    assign count    = n_filled ? i_window : slot_cmp[WIN_W-1:0];

    assign div_req.start    = (r_state == ST_UPD);
    assign div_req.dividend = n_total;
    assign div_req.divisor  = count;

    assign o_pop     = (r_state == ST_IDLE) && i_item.valid;
    assign o_valid   = r_o_valid;
    assign o_average = r_o_avg;

    rwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= '0;
            r_total   <= '0;
            r_filled  <= 1'b0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (i_clear) begin
            r_slot   <= '0;
            r_total  <= '0;
            r_filled <= 1'b0;
            r_vld    <= '0;
        end else begin
            if (r_o_valid && i_ready && (r_state != ST_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_sample <= i_item.sample;
                        r_state  <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_total       <= n_total;
                    r_slot        <= n_slot;
                    r_filled      <= n_filled;
                    r_vld[r_slot] <= 1'b1;
                    r_state       <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_res   <= div_rsp.quotient;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_avg   <= r_res;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_slot];
        r_rd_vld  <= r_vld[r_slot];
        if (r_state == ST_UPD) begin
            r_mem[r_slot] <= r_sample;
        end
    end

endmodule

/* rtl/running_window_average.sv */
// Running average of signed 16-bit samples over a window of recent items.
// Input channel: i_valid / o_ready with i_sample. Output channel: o_valid /
// i_ready with o_average, exactly one result per input item, in order.
// Configuration: an APB-style port holds the window length at address 0.
// Values below 2 read as 2 and values above DEPTH read as DEPTH; a write
// clears the stored samples, the running sum and the fill state.
// From acceptance an item passes through the input queue, the sample store
// read, the serial divider that produces one quotient bit per cycle, the
// quotient capture and the output register. The divider handles one item
// at a time, so the next item leaves the queue only once the previous
// result has been loaded into the output register.
// A two-entry input queue takes items while the divider is busy, and
// the output register holds a finished result while i_ready is low; when
// the queue is full o_ready drops.
// Reset (synchronous, i_rst_n low) empties the queue and output register,
// clears the store and sum, and sets the window length to 16 (or DEPTH if
// smaller).
module running_window_average #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [rwa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rwa_pkg::SAMPLE_W-1:0] o_average,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rwa_pkg::ADDR_W-1:0]          paddr,
    input  logic [rwa_pkg::DATA_W-1:0]          pwdata,
    output logic [rwa_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import rwa_pkg::*;

    localparam int WinMaxI = (DEPTH > 31) ? 31 : DEPTH;
    localparam int WinRstI = (DEPTH > 16) ? 16 : DEPTH;
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(WinMaxI);
    localparam logic [WIN_W-1:0] WIN_RST = WIN_W'(WinRstI);

    logic [WIN_W-1:0] r_window;
    logic [WIN_W-1:0] raw_win;
    logic [WIN_W-1:0] n_window;
    logic             cfg_wr;
    t_q_item          q_item;
    logic             q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
    assign raw_win = pwdata[WIN_W-1:0];
    assign prdata  = (paddr[2] == REG_WINDOW) ? DATA_W'(r_window) : '0;

    always_comb begin
        priority if (raw_win < WIN_MIN) begin
            n_window = WIN_MIN;
        end else if (raw_win > WIN_MAX) begin
            n_window = WIN_MAX;
        end else begin
            n_window = raw_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= (WIN_RST < WIN_RESET) ? WIN_RST : WIN_RESET;
        end else if (cfg_wr) begin
            r_window <= n_window;
        end
    end

    rwa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .o_item   (q_item),
        .i_pop    (q_pop)
    );

    rwa_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_wr),
        .i_window  (r_window),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_average (o_average)
    );

endmodule

/* dv/tb.sv */
module tb;
    import rwa_pkg::*;

    localparam int RING_DEPTH    = 16;
    localparam int IDLE_PCT      = 24;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASES        = 12;
    localparam int WINDOW_PLAN [7] = '{2, 16, 31, 0, 1, 17, 5};

    localparam logic [ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW, 2'b00};

    localparam logic signed [SAMPLE_W-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       i_valid  = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_valid;
    logic                       i_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0] o_average;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [ADDR_W-1:0]          paddr    = '0;
    logic [DATA_W-1:0]          pwdata   = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // Shadow copy of the block's window state.
    logic signed [SAMPLE_W-1:0] shadow_ring [RING_DEPTH];
    int                         shadow_slot;
    int                         shadow_total;
    logic                       shadow_filled;
    int                         shadow_window;

    logic signed [SAMPLE_W-1:0] sample_backlog [$];
    logic signed [SAMPLE_W-1:0] average_due [$];
    logic signed [SAMPLE_W-1:0] want_average;

    logic in_taken = 1'b0;
    int   idle_pct = IDLE_PCT;
    int   stall_cycles = 0;
    int   mismatches = 0;
    int   samples_sent = 0;
    int   averages_checked = 0;
    int   writes_done = 0;

    running_window_average #(
        .DEPTH(RING_DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_average(o_average),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_shadow();
        foreach (shadow_ring[k]) shadow_ring[k] = '0;
        shadow_slot   = 0;
        shadow_total  = 0;
        shadow_filled = 1'b0;
    endtask

    // Replaces the oldest entry and returns the new mean, truncated toward zero.
    function automatic logic signed [SAMPLE_W-1:0] advance_window(
        logic signed [SAMPLE_W-1:0] s
    );
        int divisor;
        int quotient;
        shadow_total = shadow_total - int'(shadow_ring[shadow_slot]) + int'(s);
        shadow_ring[shadow_slot] = s;
        shadow_slot++;
        if (shadow_slot >= shadow_window) begin
            shadow_slot   = 0;
            shadow_filled = 1'b1;
        end
        divisor  = shadow_filled ? shadow_window : shadow_slot;
        quotient = shadow_total / divisor;
        return quotient[SAMPLE_W-1:0];
    endfunction

    // Returns just after a rising edge once nothing is queued, offered or owed.
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (sample_backlog.size() != 0 || i_valid || average_due.size() != 0);
    endtask

    task automatic write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        int code;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[ADDR_W-1:2] == REG_WINDOW) begin
            code = int'(data[WIN_W-1:0]);
            shadow_window = (code < WIN_MIN) ? int'(WIN_MIN) :
                            (code > RING_DEPTH) ? RING_DEPTH : code;
            clear_shadow();
        end
        writes_done++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        #1;
    endtask

    // Mostly arbitrary samples, with small values near zero and runs of one
    // extreme long enough to fill the whole window.
    task automatic queue_random(int count);
        int n;
        int pick;
        logic signed [SAMPLE_W-1:0] level;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                level = $urandom_range(1) ? MAX_SAMPLE : MIN_SAMPLE;
                repeat (shadow_window + 2) sample_backlog.push_back(level);
                n += shadow_window + 2;
            end else if (pick < 30) begin
                level = SAMPLE_W'($urandom_range(16));
                sample_backlog.push_back(level - 16'sd8);
                n++;
            end else begin
                level = SAMPLE_W'($urandom);
                sample_backlog.push_back(level);
                n++;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_valid  <= 1'b1;
                i_sample <= sample_backlog.pop_front();
            end else begin
                i_valid  <= 1'b0;
                i_sample <= SAMPLE_W'($urandom);
            end
        end
        i_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            average_due.push_back(advance_window(i_sample));
            samples_sent++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            averages_checked++;
            if (average_due.size() == 0) begin
                $error("average: no item outstanding, actual %0d", o_average);
                mismatches++;
            end else begin
                want_average = average_due.pop_front();
                if (o_average !== want_average) begin
                    $error("average: expected %0d, actual %0d", want_average, o_average);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) ||
            (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int code;
        int count;
        clear_shadow();
        shadow_window = (WIN_RESET > RING_DEPTH) ? RING_DEPTH : int'(WIN_RESET);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Reset window, partly filled: the divisor is the count so far.
        sample_backlog.push_back(MAX_SAMPLE);
        sample_backlog.push_back(MIN_SAMPLE);
        sample_backlog.push_back(-16'sd1);
        sample_backlog.push_back(16'sd1);
        sample_backlog.push_back(16'sd0);
        wait_quiet();

        // A window code of zero reads as two.
        write_register(WINDOW_ADDR, '0);
        repeat (3) sample_backlog.push_back(MIN_SAMPLE);
        repeat (2) sample_backlog.push_back(MAX_SAMPLE);
        sample_backlog.push_back(-16'sd1);
        sample_backlog.push_back(16'sd0);
        sample_backlog.push_back(-16'sd3);
        wait_quiet();

        // A write to an unused address leaves the window and the samples alone.
        write_register(SPARE_ADDR, 32'h0000_0003);
        sample_backlog.push_back(16'sd5);
        sample_backlog.push_back(16'sd7);
        wait_quiet();

        write_register(WINDOW_ADDR, 32'h0000_0001);
        sample_backlog.push_back(16'sd1);
        sample_backlog.push_back(16'sd2);
        sample_backlog.push_back(16'sd3);
        wait_quiet();

        for (int p = 0; p < PHASES; p++) begin
            code = (p < 7) ? WINDOW_PLAN[p] : $urandom_range(31);
            write_register(WINDOW_ADDR, ($urandom & ~32'h1F) | code);
            if (p == 9) begin
                write_register(SPARE_ADDR, $urandom);
            end
            // One long phase runs with both sides always willing.
            idle_pct = (p == 4) ? 0 : IDLE_PCT;
            count = (p == 4) ? 300 : 160;
            queue_random(count / 2);
            if (p % 3 == 1) begin
                // Sender holds off until the block has drained completely.
                wait_quiet();
            end
            queue_random(count - count / 2);
            wait_quiet();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d averages from %0d samples across %0d register writes,",
                 averages_checked, samples_sent, writes_done);
        $display("covering clamped, saturated and unused-address window writes.");
        if (mismatches == 0 && average_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
